[rtl/cmdm_pkg.sv]
// shared types and constants of the constellation mapper and demapper
package cmdm_pkg;

  // default table shape
  localparam int unsigned MaxPointsDef  = 256;
  localparam int unsigned CoordWidthDef = 16;

  // field widths fixed by the ports
  localparam int unsigned IdxWidth  = 8;
  localparam int unsigned PortCoord = 16;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MAP   = 2'd1;
  localparam logic [1:0] CMD_DEMAP = 2'd2;

  // register index taken from paddr[2]
  localparam logic CFG_LOG_POINTS = 1'b0;

  // one table entry read for the demap search
  typedef struct packed {
    logic                valid;
    logic [IdxWidth-1:0] idx;
  } cmdm_tap_t;

endpackage

[rtl/cmdm_scan.sv]
// distance pipeline and running minimum of the demap search
module cmdm_scan #(
  parameter int unsigned CoordWidth = cmdm_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmdm_pkg::cmdm_tap_t           tap_i,
  input  logic signed [CoordWidth-1:0]  tbl_re_i,
  input  logic signed [CoordWidth-1:0]  tbl_im_i,
  input  logic signed [CoordWidth-1:0]  ref_re_i,
  input  logic signed [CoordWidth-1:0]  ref_im_i,
  output logic [cmdm_pkg::IdxWidth-1:0] best_idx_o,
  output logic                          busy_o
);

  localparam int unsigned SqWidth   = 2 * CoordWidth + 1;
  localparam int unsigned DistWidth = SqWidth + 1;

  logic signed [CoordWidth:0]     d_re, d_im;
  logic signed [2*CoordWidth+1:0] p_re, p_im;
  logic [SqWidth-1:0]             sq_re_q, sq_im_q;
  logic                           v2_q;
  logic [cmdm_pkg::IdxWidth-1:0]  idx2_q;
  logic [DistWidth-1:0]           sum_dist;
  logic [DistWidth-1:0]           best_dist_q;
  logic [cmdm_pkg::IdxWidth-1:0]  best_idx_q;

  // stage 1: differences and squares
  assign d_re = (CoordWidth+1)'(ref_re_i) - (CoordWidth+1)'(tbl_re_i);
  assign d_im = (CoordWidth+1)'(ref_im_i) - (CoordWidth+1)'(tbl_im_i);
  assign p_re = d_re * d_re;
  assign p_im = d_im * d_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= tap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_i.valid) begin
      sq_re_q <= p_re[SqWidth-1:0];
      sq_im_q <= p_im[SqWidth-1:0];
      idx2_q  <= tap_i.idx;
    end
  end

  // stage 2: sum and compare, first entry always loads, ties keep the lower index
  assign sum_dist = DistWidth'(sq_re_q) + DistWidth'(sq_im_q);

  always_ff @(posedge clk_i) begin
    if (v2_q && ((idx2_q == '0) || (sum_dist < best_dist_q))) begin
      best_dist_q <= sum_dist;
      best_idx_q  <= idx2_q;
    end
  end

  assign best_idx_o = best_idx_q;
  assign busy_o     = v2_q;

endmodule

[rtl/constellation_map_demap_top.sv]
// top level of the programmable constellation mapper and hard-decision demapper
//
// the point table is one synchronous memory of MaxPoints entries, each holding the
// real and imaginary coordinate side by side, with a single write port and a single
// registered read port; entries hold garbage until written. one input beat is handled
// at a time. a write or a map goes straight to the finish state to load its result.
// a demap walks entries 0 .. n-1 (n = 2^log_points, clamped to 2..256 and to
// MaxPoints) one memory read per cycle in the scan state, paced by the single read
// port; the distance pipeline behind it (square, then sum and compare) is drained
// before the finish state. results sit in an output register, so the next input
// beat is taken as soon as the previous result has moved there, even while the
// downstream side still stalls. log_points lives at byte address 0 of the apb port.
// it is to be written only while the block is idle; the block does not enforce it.
module constellation_map_demap_top #(
  parameter int unsigned MaxPoints  = cmdm_pkg::MaxPointsDef,
  parameter int unsigned CoordWidth = cmdm_pkg::CoordWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          symbol_index_i,
  input  logic signed [15:0]  point_real_i,
  input  logic signed [15:0]  point_imag_i,
  // result beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          found_index_o,
  output logic signed [15:0]  out_real_o,
  output logic signed [15:0]  out_imag_o,
  output logic                bad_index_o
);

  localparam int unsigned AddrWidth = $clog2(MaxPoints);
  // index arithmetic wide enough for the symbol index, the table depth and 256
  localparam int unsigned IxWidth   = ((AddrWidth > 8) ? AddrWidth : 8) + 1;
  localparam int unsigned ExtWidth  = (CoordWidth > 16) ? CoordWidth : 16;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  // configuration
  logic [3:0] log_points_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == cmdm_pkg::CFG_LOG_POINTS);
  assign prdata = (paddr[2] == cmdm_pkg::CFG_LOG_POINTS) ? 32'(log_points_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_points_q <= 4'd1;
    end else if (cfg_wr) begin
      log_points_q <= pwdata[3:0];
    end
  end

  // points in use: 2^log_points with log_points clamped to 1..8, capped at the depth
  logic [3:0]         lg;
  logic [IxWidth-1:0] pow2, n_use, depth;

  assign depth = IxWidth'(MaxPoints);

  always_comb begin
    lg = log_points_q;
    if (lg == 4'd0) begin
      lg = 4'd1;
    end else if (lg > 4'd8) begin
      lg = 4'd8;
    end
    pow2  = IxWidth'(1) << lg;
    n_use = (pow2 > depth) ? depth : pow2;
  end

  // input side
  logic                         in_acc;
  logic [IxWidth-1:0]           idx_w;
  logic signed [ExtWidth-1:0]   in_re_x, in_im_x;
  logic signed [CoordWidth-1:0] in_re, in_im;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_w      = IxWidth'(symbol_index_i);
  assign in_re_x    = ExtWidth'(point_real_i);
  assign in_im_x    = ExtWidth'(point_imag_i);
  assign in_re      = in_re_x[CoordWidth-1:0];
  assign in_im      = in_im_x[CoordWidth-1:0];

  // held copy of the beat under work
  logic [1:0]                   cmd_q;
  logic [7:0]                   idx_q;
  logic signed [CoordWidth-1:0] ref_re_q, ref_im_q;
  logic                         bad_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= cmd_i;
      idx_q    <= symbol_index_i;
      ref_re_q <= in_re;
      ref_im_q <= in_im;
      bad_q    <= !(idx_w < n_use);
    end
  end

  // point table
  logic [2*CoordWidth-1:0] mem_q [MaxPoints];
  logic [2*CoordWidth-1:0] rd_data_q;
  logic                    wr_en, rd_en;
  logic [AddrWidth-1:0]    rd_addr;
  logic [IxWidth-1:0]      iss_q, iss_d;
  cmdm_pkg::cmdm_tap_t     tap_q, tap_d;

  assign wr_en = in_acc && (cmd_i == cmdm_pkg::CMD_WRITE) && (idx_w < depth);

  // read issue: a map reads its entry at acceptance, a demap starts at entry 0
  // there and continues one entry a cycle in the scan state
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    iss_d       = iss_q;
    tap_d.valid = 1'b0;
    tap_d.idx   = '0;
    if (in_acc && (cmd_i == cmdm_pkg::CMD_MAP) && (idx_w < n_use)) begin
      rd_en   = 1'b1;
      rd_addr = idx_w[AddrWidth-1:0];
    end else if (in_acc && (cmd_i == cmdm_pkg::CMD_DEMAP)) begin
      rd_en       = 1'b1;
      tap_d.valid = 1'b1;
      iss_d       = IxWidth'(1);
    end else if ((state_q == ST_SCAN) && (iss_q < n_use)) begin
      rd_en       = 1'b1;
      rd_addr     = iss_q[AddrWidth-1:0];
      tap_d.valid = 1'b1;
      tap_d.idx   = iss_q[7:0];
      iss_d       = IxWidth'(iss_q + 1'b1);
    end
  end

  // a write and a read never fall in the same cycle, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_w[AddrWidth-1:0]] <= {in_re, in_im};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q       <= '0;
      tap_q.valid <= 1'b0;
      tap_q.idx   <= '0;
    end else begin
      iss_q <= iss_d;
      tap_q <= tap_d;
    end
  end

  logic signed [CoordWidth-1:0] tbl_re, tbl_im;

  assign tbl_re = rd_data_q[2*CoordWidth-1:CoordWidth];
  assign tbl_im = rd_data_q[CoordWidth-1:0];

  // distance search
  logic [7:0] best_idx;
  logic       scan_busy;

  cmdm_scan #(
    .CoordWidth(CoordWidth)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tap_i     (tap_q),
    .tbl_re_i  (tbl_re),
    .tbl_im_i  (tbl_im),
    .ref_re_i  (ref_re_q),
    .ref_im_i  (ref_im_q),
    .best_idx_o(best_idx),
    .busy_o    (scan_busy)
  );

  // output register
  logic                       out_valid_q;
  logic [7:0]                 found_q;
  logic signed [15:0]         out_re_q, out_im_q;
  logic                       out_bad_q;
  logic                       load;
  logic                       map_ok;
  logic signed [ExtWidth-1:0] tbl_re_x, tbl_im_x;

  assign load     = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign map_ok   = (cmd_q == cmdm_pkg::CMD_MAP) && !bad_q;
  assign tbl_re_x = ExtWidth'(tbl_re);
  assign tbl_im_x = ExtWidth'(tbl_im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q   <= (cmd_q == cmdm_pkg::CMD_DEMAP) ? best_idx : idx_q;
      out_re_q  <= map_ok ? tbl_re_x[15:0] : '0;
      out_im_q  <= map_ok ? tbl_im_x[15:0] : '0;
      out_bad_q <= (cmd_q == cmdm_pkg::CMD_MAP) && bad_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_index_o = found_q;
  assign out_real_o    = out_re_q;
  assign out_imag_o    = out_im_q;
  assign bad_index_o   = out_bad_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (cmd_i == cmdm_pkg::CMD_DEMAP) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        // all reads issued and the distance pipeline drained
        if ((iss_q == n_use) && !tap_q.valid && !scan_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/cmdm_checker.sv]
// port-level checks of the constellation mapper and demapper, bound to the top level
module cmdm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] out_real_o,
  input logic signed [15:0] out_imag_o,
  input logic               bad_index_o
);

  // a pending result is never dropped while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // one item at a time: a taken beat closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the previous item finished");

  // a bad map index carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> (out_real_o == '0) && (out_imag_o == '0))
    else $error("bad index with nonzero coordinates");

  // the configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind constellation_map_demap_top cmdm_checker u_cmdm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pready     (pready),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_real_o (out_real_o),
  .out_imag_o (out_imag_o),
  .bad_index_o(bad_index_o)
);

[bench/tb_top.sv]
// self-checking testbench for the constellation mapper and hard-decision demapper
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // the one command code the package leaves unnamed: accepted, changes nothing
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // log_points sits at byte address 0, register index taken from paddr[2]
  localparam logic [2:0] ADDR_LOG_POINTS = {cmdm_pkg::CFG_LOG_POINTS, 2'b00};

  localparam int unsigned TABLE_DEPTH = 256;
  localparam logic signed [15:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [15:0] COORD_MIN = 16'sh8000;
  // the tail waits past the slowest demap for a stray beat
  localparam int unsigned DRAIN_TAIL = 400;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [7:0]          idx;
    logic signed [15:0]  re;
    logic signed [15:0]  im;
  } sym_beat_t;

  typedef struct packed {
    logic [7:0]          found;
    logic signed [15:0]  re;
    logic signed [15:0]  im;
    logic                bad;
  } sym_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // apb side, idle from time zero
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // input beats
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i          = '0;
  logic [7:0]         symbol_index_i = '0;
  logic signed [15:0] point_real_i   = '0;
  logic signed [15:0] point_imag_i   = '0;

  // result beats
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [7:0]         found_index_o;
  logic signed [15:0] out_real_o;
  logic signed [15:0] out_imag_o;
  logic               bad_index_o;

  // predictor state: our own copy of the point table and of log_points
  logic signed [15:0] pt_re [TABLE_DEPTH];
  logic signed [15:0] pt_im [TABLE_DEPTH];
  bit                 entry_loaded [TABLE_DEPTH];
  logic [3:0]         cfg_log_points = 4'd1;

  // results still owed by the block, oldest first
  sym_result_t pending_symbols [$];

  int unsigned mismatches      = 0;
  longint      cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned send_calm_left  = 0;
  int unsigned stall_calm_left = 0;

  constellation_map_demap_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .symbol_index_i (symbol_index_i),
    .point_real_i   (point_real_i),
    .point_imag_i   (point_imag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_index_o  (found_index_o),
    .out_real_o     (out_real_o),
    .out_imag_o     (out_imag_o),
    .bad_index_o    (bad_index_o)
  );

  always #2 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("constellation_map_demap_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // 2^log_points with 0 read as 1 and anything above 8 read as 8
  function automatic int unsigned active_points(input logic [3:0] lg);
    int unsigned eff;
    eff = (lg < 4'd1) ? 1 : ((lg > 4'd8) ? 8 : int'(lg));
    return (1 << eff) > TABLE_DEPTH ? TABLE_DEPTH : (1 << eff);
  endfunction

  function automatic logic signed [15:0] clamp_coord(input longint v);
    if (v > 32767) return COORD_MAX;
    if (v < -32768) return COORD_MIN;
    return v[15:0];
  endfunction

  function automatic sym_beat_t mk_beat(input logic [1:0] cmd, input logic [7:0] idx,
                                        input logic signed [15:0] re,
                                        input logic signed [15:0] im);
    sym_beat_t b;
    b.cmd = cmd;
    b.idx = idx;
    b.re  = re;
    b.im  = im;
    return b;
  endfunction

  // applies one accepted beat to the predicted table and returns the answer it owes
  function automatic sym_result_t mapper_response(input sym_beat_t beat);
    sym_result_t res;
    int unsigned n;
    int unsigned i;
    longint      dr;
    longint      di;
    longint      sq_dist;
    longint      best_dist;
    res.found = beat.idx;
    res.re    = '0;
    res.im    = '0;
    res.bad   = 1'b0;
    n = active_points(cfg_log_points);
    case (beat.cmd)
      cmdm_pkg::CMD_WRITE: begin
        // writes ignore log_points, any entry can be loaded
        pt_re[beat.idx]        = beat.re;
        pt_im[beat.idx]        = beat.im;
        entry_loaded[beat.idx] = 1'b1;
      end
      cmdm_pkg::CMD_MAP: begin
        if (beat.idx < n) begin
          res.re = pt_re[beat.idx];
          res.im = pt_im[beat.idx];
        end else begin
          res.bad = 1'b1;
        end
      end
      cmdm_pkg::CMD_DEMAP: begin
        // exact squared distance, strict less-than keeps the lowest index on a tie
        best_dist = 0;
        res.found = '0;
        for (i = 0; i < n; i++) begin
          dr      = longint'($signed(beat.re)) - longint'(pt_re[i]);
          di      = longint'($signed(beat.im)) - longint'(pt_im[i]);
          sq_dist = dr * dr + di * di;
          if (i == 0 || sq_dist < best_dist) begin
            best_dist = sq_dist;
            res.found = i[7:0];
          end
        end
      end
      default: begin
        // spare command: echo only
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // every result beat is matched against the oldest owed answer
  always @(posedge clk) begin
    sym_result_t want;
    if (rst_n && out_valid_o && !out_stall_i) begin
      if (pending_symbols.size() == 0) begin
        note_mismatch("unrequested result beat", {24'd0, found_index_o}, 32'd0);
      end else begin
        want = pending_symbols.pop_front();
        if (found_index_o !== want.found)
          note_mismatch("found_index", {24'd0, found_index_o}, {24'd0, want.found});
        if (out_real_o !== want.re)
          note_mismatch("out_real", {16'd0, out_real_o}, {16'd0, want.re});
        if (out_imag_o !== want.im)
          note_mismatch("out_imag", {16'd0, out_imag_o}, {16'd0, want.im});
        if (bad_index_o !== want.bad)
          note_mismatch("bad_index", {31'd0, bad_index_o}, {31'd0, want.bad});
      end
    end
  end

  // receiver back-pressure, with occasional calm stretches of no stall at all
  always @(posedge clk) begin
    if (stall_calm_left > 0) begin
      stall_calm_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(199) == 0) begin
      stall_calm_left = $urandom_range(60, 10);
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plumbing
  // ---------------------------------------------------------------------------

  // one input beat: random idle gap, then hold valid until the block takes it
  task automatic send_beat(input sym_beat_t beat);
    int unsigned gap;
    gap = 0;
    if (send_calm_left > 0) begin
      send_calm_left--;
    end else if ($urandom_range(149) == 0) begin
      send_calm_left = $urandom_range(40, 10);
    end else begin
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= beat.cmd;
    symbol_index_i <= beat.idx;
    point_real_i   <= beat.re;
    point_imag_i   <= beat.im;
    do @(posedge clk); while (in_stall_o);
    pending_symbols.push_back(mapper_response(beat));
  endtask

  // stop sending and wait until every owed result has come out
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk); while (pending_symbols.size() != 0);
  endtask

  // block is idle here: write log_points, then read it straight back
  task automatic program_log_points(input logic [3:0] value);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_LOG_POINTS;
    pwdata  <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_log_points = value;
    // read setup follows the write access directly
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[3:0] !== value)
      note_mismatch("log_points readback", {28'd0, prdata[3:0]}, {28'd0, value});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // make sure every entry in use holds a written point before any read of it
  task automatic load_points_in_use();
    int unsigned n;
    int unsigned i;
    sym_beat_t   beat;
    n = active_points(cfg_log_points);
    for (i = 0; i < n; i++) begin
      if (!entry_loaded[i]) begin
        beat = mk_beat(cmdm_pkg::CMD_WRITE, i[7:0], 16'($urandom), 16'($urandom));
        if ($urandom_range(7) == 0) begin
          beat.re = $urandom_range(1) ? COORD_MAX : COORD_MIN;
          beat.im = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        end
        send_beat(beat);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset setting of two points: extremes, every command, ties, out-of-range maps
  task automatic test_directed_points();
    send_idle_pct  = 12;
    recv_stall_pct = 60;
    send_beat(mk_beat(cmdm_pkg::CMD_WRITE, 8'd0, COORD_MAX, COORD_MAX));
    send_beat(mk_beat(cmdm_pkg::CMD_WRITE, 8'd1, COORD_MIN, COORD_MIN));
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd0, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd1, COORD_MAX, COORD_MIN));
    // first index past the points in use, and the top index
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd2, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'hff, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'h00, COORD_MAX, COORD_MAX));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'hff, COORD_MIN, COORD_MIN));
    // just either side of the midpoint between the two corners
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'h5a, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'ha5, -16'sd1, -16'sd1));
    // equal points: the lower index wins
    send_beat(mk_beat(cmdm_pkg::CMD_WRITE, 8'd1, COORD_MAX, COORD_MAX));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'd1, 16'sd0, 16'sd0));
    // writes outside the points in use still land
    send_beat(mk_beat(cmdm_pkg::CMD_WRITE, 8'hff, COORD_MIN, COORD_MAX));
    send_beat(mk_beat(cmdm_pkg::CMD_WRITE, 8'h80, 16'sh5555, 16'shaaaa));
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'hff, 16'sd0, 16'sd0));
    // spare command echoes the index and nothing else
    send_beat(mk_beat(CMD_SPARE, 8'ha5, COORD_MAX, COORD_MIN));
    send_beat(mk_beat(CMD_SPARE, 8'h5a, COORD_MIN, COORD_MAX));
    send_beat(mk_beat(cmdm_pkg::CMD_WRITE, 8'd1, COORD_MIN, COORD_MAX));
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd1, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'h3c, COORD_MAX, COORD_MIN));
  endtask

  // register at and past both ends, with the full table in use
  task automatic test_register_extremes();
    sym_beat_t beat;
    // zero reads as one bit per symbol
    program_log_points(4'd0);
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd1, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd2, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'd7, COORD_MIN, COORD_MAX));
    // fifteen reads as eight: all 256 entries in use
    program_log_points(4'd15);
    load_points_in_use();
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'hff, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'd0, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'd0, COORD_MIN, COORD_MIN));
    // tie at the top of the table
    beat = mk_beat(cmdm_pkg::CMD_WRITE, 8'hff, pt_re[254], pt_im[254]);
    send_beat(beat);
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'h11, beat.re, beat.im));
    program_log_points(4'd8);
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'hfe, 16'sd0, 16'sd0));
    send_beat(mk_beat(cmdm_pkg::CMD_DEMAP, 8'h22, COORD_MAX, COORD_MAX));
    program_log_points(4'd9);
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'hff, 16'sd0, 16'sd0));
    program_log_points(4'd1);
    send_beat(mk_beat(cmdm_pkg::CMD_MAP, 8'd2, 16'sd0, 16'sd0));
  endtask

  // random mix under one idling pattern; log_points changes every few dozen beats,
  // mostly to small tables so the long full-table demaps stay few
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned count);
    sym_beat_t   beat;
    int unsigned n;
    int unsigned j;
    int unsigned k;
    int unsigned pick;
    int unsigned left_in_phase;
    int unsigned b;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    left_in_phase  = 0;
    for (b = 0; b < count; b++) begin
      if (left_in_phase == 0) begin
        if ($urandom_range(99) < 75)
          program_log_points(4'($urandom_range(5, 0)));
        else
          program_log_points(4'($urandom_range(15, 6)));
        load_points_in_use();
        left_in_phase = $urandom_range(60, 20);
      end
      left_in_phase--;
      n = active_points(cfg_log_points);
      // now and then the sender holds off until the pipe is empty
      if ($urandom_range(39) == 0) wait_results_drained();
      beat = mk_beat(cmdm_pkg::CMD_DEMAP, 8'($urandom), 16'($urandom), 16'($urandom));
      pick = $urandom_range(99);
      if (pick < 25) begin
        beat.cmd = cmdm_pkg::CMD_WRITE;
        if ($urandom_range(3) != 0) beat.idx = 8'($urandom_range(n - 1, 0));
        // copy a lower entry so the demap search meets exact ties
        if (beat.idx > 0 && $urandom_range(3) == 0) begin
          j = $urandom_range(beat.idx - 1, 0);
          if (entry_loaded[j]) begin
            beat.re = pt_re[j];
            beat.im = pt_im[j];
          end
        end
      end else if (pick < 55) begin
        beat.cmd = cmdm_pkg::CMD_MAP;
        if ($urandom_range(1) == 0) beat.idx = 8'($urandom_range(n - 1, 0));
      end else if (pick < 95) begin
        j = $urandom_range(n - 1, 0);
        k = $urandom_range(n - 1, 0);
        case ($urandom_range(3))
          0: begin
            // anywhere in the plane
          end
          1: begin
            beat.re = pt_re[j];
            beat.im = pt_im[j];
          end
          2: begin
            beat.re = clamp_coord(longint'(pt_re[j]) + $urandom_range(256, 0) - 128);
            beat.im = clamp_coord(longint'(pt_im[j]) + $urandom_range(256, 0) - 128);
          end
          default: begin
            // midpoint of two entries, often equidistant
            beat.re = clamp_coord((longint'(pt_re[j]) + longint'(pt_re[k])) / 2);
            beat.im = clamp_coord((longint'(pt_im[j]) + longint'(pt_im[k])) / 2);
          end
        endcase
      end else begin
        beat.cmd = CMD_SPARE;
      end
      send_beat(beat);
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_register_extremes();
    // receiver sparse then sender sparse, then both flat out
    test_random_traffic(12, 60, 240);
    test_random_traffic(60, 12, 240);
    test_random_traffic(0, 0, 240);
    wait_results_drained();
    // leave room for a stray beat to show up
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && pending_symbols.size() == 0) begin
      $display("constellation_map_demap_top verification clean");
    end else begin
      $display("constellation_map_demap_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cmdm_pkg.sv
rtl/cmdm_scan.sv
rtl/constellation_map_demap_top.sv
rtl/cmdm_checker.sv
bench/tb_top.sv
